FILE: design/sid_pkg.sv
`timescale 1ns / 1ps
package sid_pkg;

  // field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned UNIT_W  = 2;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned REP_W   = 17;
  localparam int unsigned TICK_W  = 11;

  // working widths: 65535 min in ms fits 32 bits, longest period 32000 ms fits 15 bits
  localparam int unsigned REM_W   = 32;
  localparam int unsigned LEN_W   = 15;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned SEG_N_W = 3;

  // periodic interrupt table and plan limits
  localparam int unsigned TABLE_LEN   = 14;
  localparam int unsigned MAX_RESULTS = 6;
  localparam logic [REP_W-1:0] REPEAT_MAX = '1;

  // defaults of the top level parameters
  localparam int unsigned DEF_RTC_CLOCK_HZ        = 1024;
  localparam int unsigned DEF_STANDBY_LIMIT_INDEX = 9;

  // time unit codes
  typedef enum logic [UNIT_W-1:0] {
    UNIT_MS  = 2'd0,
    UNIT_S   = 2'd1,
    UNIT_MIN = 2'd2,
    UNIT_BAD = 2'd3
  } unit_e;

  localparam logic [REM_W-1:0] MS_PER_S   = 32'd1000;
  localparam logic [REM_W-1:0] MS_PER_MIN = 32'd60000;

  // segment modes
  typedef enum logic {
    MODE_PDOWN   = 1'b0,
    MODE_STANDBY = 1'b1
  } mode_e;

  // one planned segment, handed from the sequencer to the output stage
  typedef struct packed {
    mode_e             mode;
    logic [CODE_W-1:0] code;
    logic [REP_W-1:0]  repeat_count;
    logic [TICK_W-1:0] ticks;
    logic              last;
  } seg_t;

endpackage

FILE: design/sleep_interval_decomposer.sv
`timescale 1ns / 1ps
// Sleep interval decomposer: takes a sleep request (16-bit value, unit ms/s/min) and
// streams out a plan of wake-up timer segments, greedy over the periodic interrupt
// periods of (4 << i) * 1000 / RTC_CLOCK_HZ ms. Each power-down word carries a period
// code and repeat count; a remainder below the standby limit ends the plan with one
// standby word of that many ms; tlast marks the final word. Unit 3 or a zero request
// gives no words. Input word: value bits 15:0, unit bits 17:16. A request is taken
// only while the block is idle. Each power-down word then passes a check state, a
// search over the periods, a restoring division and an emit state that hands it off;
// a standby word passes the check and emit states. The divide dominates: one 32-bit
// subtractor, shared by the standby check, the period search and a restoring
// division, runs one quotient bit per cycle. The last word may sit in the output
// register while the next request is taken.
module sleep_interval_decomposer #(
  parameter int unsigned RTC_CLOCK_HZ        = sid_pkg::DEF_RTC_CLOCK_HZ,
  parameter int unsigned STANDBY_LIMIT_INDEX = sid_pkg::DEF_STANDBY_LIMIT_INDEX
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // period_value, period_unit, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pit_code, repeat_count, standby_ticks
  output logic        m_axis_tuser,   // sleep_mode
  output logic        m_axis_tlast    // last_segment
);
  import sid_pkg::*;

  logic [VALUE_W-1:0] period_value;
  logic [UNIT_W-1:0]  period_unit;
  logic               slot_free;
  logic               seg_valid;
  seg_t               seg;
  logic               out_valid_q;
  seg_t               out_q;

  assign period_value = s_axis_tdata[VALUE_W-1:0];
  assign period_unit  = s_axis_tdata[VALUE_W +: UNIT_W];

  sid_ctrl #(
    .RTC_CLOCK_HZ        (RTC_CLOCK_HZ),
    .STANDBY_LIMIT_INDEX (STANDBY_LIMIT_INDEX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .value_i     (period_value),
    .unit_i      (period_unit),
    .slot_free_i (slot_free),
    .seg_valid_o (seg_valid),
    .seg_o       (seg)
  );

  // output register, refilled as the current word leaves
  assign slot_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= seg_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_valid) begin
      out_q <= seg;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.ticks, out_q.repeat_count, out_q.code};
  assign m_axis_tuser  = out_q.mode;
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: design/sid_alu.sv
`timescale 1ns / 1ps
module sid_alu (
  input  logic [sid_pkg::REM_W-1:0] a_i,
  input  logic [sid_pkg::REM_W-1:0] b_i,
  output logic [sid_pkg::REM_W-1:0] diff_o,
  output logic                      borrow_o
);
  import sid_pkg::*;

  // shared subtractor, borrow means a < b
  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

FILE: design/sid_ctrl.sv
`timescale 1ns / 1ps
module sid_ctrl #(
  parameter int unsigned RTC_CLOCK_HZ        = sid_pkg::DEF_RTC_CLOCK_HZ,
  parameter int unsigned STANDBY_LIMIT_INDEX = sid_pkg::DEF_STANDBY_LIMIT_INDEX
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sid_pkg::VALUE_W-1:0] value_i,
  input  logic [sid_pkg::UNIT_W-1:0]  unit_i,
  input  logic                        slot_free_i,
  output logic                        seg_valid_o,
  output sid_pkg::seg_t               seg_o
);
  import sid_pkg::*;

  localparam int unsigned LIM_INT = (STANDBY_LIMIT_INDEX >= TABLE_LEN) ?
                                    (TABLE_LEN - 1) : STANDBY_LIMIT_INDEX;
  localparam logic [IDX_W-1:0] LIM      = IDX_W'(LIM_INT);
  localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(TABLE_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REM_W - 1);
  localparam logic [SEG_N_W-1:0] N_LAST = SEG_N_W'(MAX_RESULTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  // period lengths in ms, worked out at elaboration
  logic [LEN_W-1:0] entry_len [TABLE_LEN];

  for (genvar g = 0; g < TABLE_LEN; g++) begin : g_tab
    localparam int unsigned RAW = ((32'd4 << g) * 32'd1000) / RTC_CLOCK_HZ;
    assign entry_len[g] = (RAW == 0) ? LEN_W'(1) : LEN_W'(RAW);
  end

  state_e             state_q, state_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [LEN_W-1:0]   part_q, part_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SEG_N_W-1:0] n_q, n_d;
  logic               stby_q, stby_d;

  logic [IDX_W-1:0]   idx_nxt;
  logic [REM_W-1:0]   alu_a, alu_b, alu_diff;
  logic               alu_borrow;
  logic [REM_W-1:0]   scaled;
  logic               seg_last;

  assign idx_nxt = (idx_q == IDX_TOP) ? idx_q : idx_q + IDX_W'(1);

  // operand select for the shared subtractor
  always_comb begin
    alu_a = rem_q;
    alu_b = '0;
    case (state_q)
      ST_CHECK:  alu_b = REM_W'(entry_len[LIM]);
      ST_SEARCH: alu_b = REM_W'(entry_len[idx_nxt]);
      ST_DIVIDE: begin
        alu_a = REM_W'({part_q, rem_q[REM_W-1]});
        alu_b = REM_W'(entry_len[idx_q]);
      end
      default: ;
    endcase
  end

  sid_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  // request in ms
  always_comb begin
    case (unit_i)
      UNIT_MS:  scaled = REM_W'(value_i);
      UNIT_S:   scaled = REM_W'(value_i) * MS_PER_S;
      UNIT_MIN: scaled = REM_W'(value_i) * MS_PER_MIN;
      default:  scaled = '0;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // segment word built from the sequencer registers
  assign seg_last = stby_q || (part_q == '0) || (n_q == N_LAST);

  always_comb begin
    seg_o.mode         = stby_q ? MODE_STANDBY : MODE_PDOWN;
    seg_o.code         = stby_q ? '0 : CODE_W'(idx_q + IDX_W'(1));
    seg_o.repeat_count = '0;
    seg_o.ticks        = '0;
    seg_o.last         = seg_last;
    if (stby_q) begin
      seg_o.ticks = rem_q[TICK_W-1:0];
    end else if (rem_q > REM_W'(REPEAT_MAX)) begin
      seg_o.repeat_count = REPEAT_MAX;
    end else begin
      seg_o.repeat_count = rem_q[REP_W-1:0];
    end
  end

  assign seg_valid_o = (state_q == ST_EMIT) && slot_free_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    part_d  = part_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    stby_d  = stby_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rem_d = scaled;
          n_d   = '0;
          if (scaled != '0) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        idx_d = LIM;
        if (alu_borrow) begin
          stby_d  = 1'b1;
          state_d = ST_EMIT;
        end else begin
          stby_d  = 1'b0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if ((idx_q == IDX_TOP) || alu_borrow) begin
          part_d  = '0;
          cnt_d   = '0;
          state_d = ST_DIVIDE;
        end else begin
          idx_d = idx_nxt;
        end
      end
      ST_DIVIDE: begin
        // one restoring step: quotient bits shift into rem from below
        if (alu_borrow) begin
          part_d = {part_q[LEN_W-2:0], rem_q[REM_W-1]};
        end else begin
          part_d = alu_diff[LEN_W-1:0];
        end
        rem_d = {rem_q[REM_W-2:0], ~alu_borrow};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free_i) begin
          n_d   = n_q + SEG_N_W'(1);
          rem_d = REM_W'(part_q);
          if (seg_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      stby_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      stby_q  <= stby_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    part_q <= part_d;
    idx_q  <= idx_d;
  end

endmodule

FILE: verif/tb_sleep_interval_decomposer.sv
`timescale 1ns / 1ps
module tb_sleep_interval_decomposer;
  import sid_pkg::*;

  localparam int unsigned NUM_REQUESTS = 440;
  localparam int unsigned IDLE_PCT     = 9;

  // expected segment plans, one entry per output word
  class segment_scoreboard;
    seg_t        plan_q[$];
    int unsigned errors = 0;

    // length of one periodic interrupt period in ms, never zero
    function logic [63:0] pit_len_ms(int unsigned idx);
      logic [63:0] len;
      len = (64'd4 << idx) * 64'd1000 / 64'(DEF_RTC_CLOCK_HZ);
      return (len == 64'd0) ? 64'd1 : len;
    endfunction

    // greedy split of an accepted request into segments
    function void note_request(logic [VALUE_W-1:0] value, unit_e unit);
      logic [63:0] remain;
      logic [63:0] len;
      logic [63:0] rep;
      int unsigned lim;
      int unsigned idx;
      int unsigned n;
      seg_t        seg;
      case (unit)
        UNIT_MS:  remain = 64'(value);
        UNIT_S:   remain = 64'(value) * 64'(MS_PER_S);
        UNIT_MIN: remain = 64'(value) * 64'(MS_PER_MIN);
        default:  return;
      endcase
      lim = (DEF_STANDBY_LIMIT_INDEX >= TABLE_LEN) ? TABLE_LEN - 1 : DEF_STANDBY_LIMIT_INDEX;
      n = 0;
      while (remain != 64'd0 && n < MAX_RESULTS) begin
        // remainder under the standby limit closes the plan
        if (remain < pit_len_ms(lim)) begin
          seg.mode         = MODE_STANDBY;
          seg.code         = '0;
          seg.repeat_count = '0;
          seg.ticks        = remain[TICK_W-1:0];
          seg.last         = 1'b0;
          plan_q.push_back(seg);
          n++;
          break;
        end
        idx = lim;
        for (int unsigned i = lim; i < TABLE_LEN; i++) begin
          if (pit_len_ms(i) <= remain) idx = i;
          else break;
        end
        len = pit_len_ms(idx);
        rep = remain / len;
        seg.mode         = MODE_PDOWN;
        seg.code         = CODE_W'(idx + 1);
        seg.repeat_count = (rep > 64'(REPEAT_MAX)) ? REPEAT_MAX : rep[REP_W-1:0];
        seg.ticks        = '0;
        seg.last         = 1'b0;
        plan_q.push_back(seg);
        n++;
        remain = remain % len;
      end
      if (n > 0) plan_q[plan_q.size() - 1].last = 1'b1;
    endfunction

    // compare one output word with the oldest expected segment
    function void check_segment(seg_t got);
      seg_t exp_seg;
      if (plan_q.size() == 0) begin
        $error("segment with nothing expected: mode %0d code %0d rep %0d ticks %0d last %0d",
               got.mode, got.code, got.repeat_count, got.ticks, got.last);
        errors++;
        return;
      end
      exp_seg = plan_q.pop_front();
      if (got.mode != exp_seg.mode) begin
        $error("sleep_mode: expected %0d, got %0d", exp_seg.mode, got.mode);
        errors++;
      end
      if (got.code != exp_seg.code) begin
        $error("pit_code: expected %0d, got %0d", exp_seg.code, got.code);
        errors++;
      end
      if (got.repeat_count != exp_seg.repeat_count) begin
        $error("repeat_count: expected %0d, got %0d", exp_seg.repeat_count, got.repeat_count);
        errors++;
      end
      if (got.ticks != exp_seg.ticks) begin
        $error("standby_ticks: expected %0d, got %0d", exp_seg.ticks, got.ticks);
        errors++;
      end
      if (got.last != exp_seg.last) begin
        $error("last_segment: expected %0d, got %0d", exp_seg.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        calm          = 1'b0;

  segment_scoreboard board = new();

  sleep_interval_decomposer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // receiver stalls at random outside the calm stretch
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // collect output words at the rising edge
  always @(posedge clk_i) begin
    seg_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.mode         = mode_e'(m_axis_tuser);
      got.code         = m_axis_tdata[3:0];
      got.repeat_count = m_axis_tdata[20:4];
      got.ticks        = m_axis_tdata[31:21];
      got.last         = m_axis_tlast;
      board.check_segment(got);
    end
  end

  // present one request and hold it until taken
  task automatic send_request(input logic [VALUE_W-1:0] value, input unit_e unit);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, unit, value};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(value, unit);
  endtask

  // random request biased toward period boundaries and short plans
  task automatic send_random();
    logic [VALUE_W-1:0] value;
    unit_e              unit;
    int unsigned        pick;
    int unsigned        boundary;
    pick = $urandom_range(15);
    unit = (pick >= 14) ? UNIT_BAD : unit_e'(pick % 3);
    case ($urandom_range(9))
      0, 1, 2, 3: value = VALUE_W'($urandom_range(65535));
      4, 5:       value = VALUE_W'($urandom_range(2100));
      6:          value = VALUE_W'(2000 * $urandom_range(32));
      7: begin
        boundary = 2000 << $urandom_range(4);
        value    = VALUE_W'(boundary + $urandom_range(4) - 2);
      end
      default:    value = VALUE_W'($urandom_range(70));
    endcase
    send_request(value, unit);
  endtask

  initial begin
    int unsigned sent;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero, invalid unit, limits and exact multiples
    send_request(16'd0, UNIT_MS);
    send_request(16'd0, UNIT_S);
    send_request(16'd0, UNIT_MIN);
    send_request(16'hFFFF, UNIT_BAD);
    send_request(16'hAAAA, UNIT_BAD);
    send_request(16'd1, UNIT_MS);
    send_request(16'd1999, UNIT_MS);
    send_request(16'd2000, UNIT_MS);
    send_request(16'd2001, UNIT_MS);
    send_request(16'd3999, UNIT_MS);
    send_request(16'd6000, UNIT_MS);
    send_request(16'd32000, UNIT_MS);
    send_request(16'd63999, UNIT_MS);
    send_request(16'd64000, UNIT_MS);
    send_request(16'hFFFF, UNIT_MS);
    send_request(16'd1, UNIT_S);
    send_request(16'd2, UNIT_S);
    send_request(16'd32, UNIT_S);
    send_request(16'hFFFF, UNIT_S);
    send_request(16'd1, UNIT_MIN);
    send_request(16'h5555, UNIT_MIN);
    send_request(16'hFFFF, UNIT_MIN);

    // random part with a calm stretch in the middle
    sent = 0;
    while (sent < NUM_REQUESTS) begin
      calm = (sent >= 150 && sent < 260);
      send_random();
      sent++;
    end
    calm = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain, then allow the last requests to settle
    while (board.plan_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
design/sid_pkg.sv
design/sid_alu.sv
design/sid_ctrl.sv
design/sleep_interval_decomposer.sv
verif/tb_sleep_interval_decomposer.sv
